/* rtl/tsff_pkg.sv */
// Shared constants and codes for the superbee face flux block.
// No dependencies; imported by the register file and the top level.

package tsff_pkg;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index taken from the word address bit of paddr
   typedef enum logic [0:0] {
      REG_COURANT_SCALE = 1'b0
   } csr_reg_type;

   // dt/dx register: unsigned, 16 integer and 16 fraction bits
   localparam int SCALE_W = 32;

   // |velocity| * dt/dx carries 32 fraction bits before rescaling
   localparam int SCALE_FRAC_BITS = 32;

   // Courant product saturates at 2.0, i.e. 2^33 in that format
   localparam int COURANT_CAP_LOG = 33;
   localparam int VSAT_W = COURANT_CAP_LOG + 1;
   localparam logic [VSAT_W-1:0] COURANT_CAP = {1'b1, {COURANT_CAP_LOG{1'b0}}};

   // Velocity magnitude is split in two halves for the partial products
   localparam int MUL_SPLIT = 17;
   localparam int PROD_W = VSAT_W + SCALE_W;

endpackage

/* rtl/tsff_csr.sv */
// Configuration register file: holds the dt/dx scale behind an APB-style port.
// Depends on tsff_pkg for address and data geometry.

module tsff_csr
   import tsff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [SCALE_W-1:0]    courant_scale
);

   logic [SCALE_W-1:0] scale_ff;
   logic               wr_en;
   csr_reg_type        reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write the scale in the access phase of a transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else if (wr_en && reg_sel == REG_COURANT_SCALE) begin
         scale_ff <= csr_pwdata[SCALE_W-1:0];
      end
   end

   // Read back decode
   always_comb begin
      unique case (reg_sel)
         REG_COURANT_SCALE: csr_prdata = CSR_DATA_W'(scale_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign courant_scale = scale_ff;

endmodule

/* rtl/tsff_ratio_div.sv */
// Pipelined restoring divider for the limiter ratio, one quotient bit per stage.
// Carries an opaque payload alongside; no package dependencies.

module tsff_ratio_div #(
   parameter int DEN_W = 17,
   parameter int QUO_W = 17,
   parameter int PAY_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [PAY_W-1:0] out_pay
);

   // Partial remainder stays below twice the divisor
   localparam int REM_W = DEN_W + 1;

   logic [QUO_W:0]   stg_valid;
   logic [REM_W-1:0] stg_rem [QUO_W+1];
   logic [QUO_W-1:0] stg_quo [QUO_W+1];
   logic [DEN_W-1:0] stg_den [QUO_W+1];
   logic [PAY_W-1:0] stg_pay [QUO_W+1];

   assign stg_valid[0] = in_valid;
   assign stg_rem[0]   = REM_W'(in_num);
   assign stg_quo[0]   = '0;
   assign stg_den[0]   = in_den;
   assign stg_pay[0]   = in_pay;

   for (genvar j = 0; j < QUO_W; j++) begin : g_bit
      logic             valid_ff;
      logic [REM_W-1:0] rem_ff;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_ff;
      logic [QUO_W-1:0] quo_in;
      logic [DEN_W-1:0] den_ff;
      logic [PAY_W-1:0] pay_ff;
      logic [REM_W-1:0] den_x;
      logic             take;

      // Trial subtract, set the quotient bit, shift the remainder on
      always_comb begin
         den_x  = REM_W'(stg_den[j]);
         take   = stg_rem[j] >= den_x;
         rem_in = (take ? (stg_rem[j] - den_x) : stg_rem[j]) << 1;
         quo_in = stg_quo[j];
         quo_in[QUO_W-1-j] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= stg_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            den_ff <= stg_den[j];
            pay_ff <= stg_pay[j];
         end
      end

      assign stg_valid[j+1] = valid_ff;
      assign stg_rem[j+1]   = rem_ff;
      assign stg_quo[j+1]   = quo_ff;
      assign stg_den[j+1]   = den_ff;
      assign stg_pay[j+1]   = pay_ff;
   end

   assign out_valid = stg_valid[QUO_W];
   assign out_quo   = stg_quo[QUO_W];
   assign out_pay   = stg_pay[QUO_W];

endmodule

/* rtl/tvd_superbee_face_flux_core.sv */
// Top level of the superbee-limited face flux pipeline.
// Depends on tsff_pkg, tsff_csr and tsff_ratio_div.
//
// Usage:
//   One cell face enters per req transaction: velocity, upwind-upwind, donor
//   and acceptor fractions in req_tdata, the upwind-upwind valid flag in
//   req_tuser. One signed flux leaves per rsp transaction, in the same order.
//   dt/dx is written through the csr port at byte address 0; the user must
//   write it only while no face is in flight, which the block does not enforce.
//   Throughput: one face per cycle while the receiver takes every result. A
//   face passes the stage 1 register, the limiter ratio divider, one quotient
//   bit per stage, stages A to F and the result register before rsp_tvalid.
//   All stages move together: when the result register holds a transaction
//   that the receiver does not take, the whole pipeline holds and req_tready
//   drops in the same cycle, so nothing is lost or repeated.
//   Reset clears every valid bit and sets dt/dx to zero; the pipeline can
//   take a face in the first cycle after reset.

module tvd_superbee_face_flux_core
   import tsff_pkg::*;
#(
   parameter int FRACTION_BITS  = 16,
   parameter int VELOCITY_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // face_velocity, upwind_upwind_fraction, donor_fraction, acceptor_fraction
   input  logic [((VELOCITY_WIDTH + 3*(FRACTION_BITS+1) + 7) / 8) * 8 - 1:0] req_tdata,
   // upwind_upwind_valid
   input  logic [0:0] req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // face_flux
   output logic [((FRACTION_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int F       = FRACTION_BITS;
   localparam int VW      = VELOCITY_WIDTH;
   localparam int FR_W    = F + 1;
   localparam int FL_W    = F + 2;
   localparam int SUM_W   = FL_W + 2;
   localparam int RSP_W   = ((FL_W + 7) / 8) * 8;
   localparam int VMAG_W  = (VW > VSAT_W) ? VW : VSAT_W;
   localparam int UU_LSB  = VW;
   localparam int DON_LSB = VW + FR_W;
   localparam int ACC_LSB = VW + 2 * FR_W;
   localparam int PLO_W   = MUL_SPLIT + SCALE_W;
   localparam int PHI_W   = VSAT_W - MUL_SPLIT + SCALE_W;
   localparam int MUL_W   = FL_W + FR_W;

   localparam logic [FL_W-1:0] ONE_FL  = FL_W'(1) << F;
   localparam logic [FL_W-1:0] HALF_FL = FL_W'(1) << (F - 1);
   localparam logic [FL_W-1:0] TWO_FL  = FL_W'(1) << (F + 1);

   typedef struct packed {
      logic [VSAT_W-1:0]      vsat;
      logic                   neg_out;
      logic [FR_W-1:0]        donor;
      logic signed [FL_W-1:0] ub;
      logic [FR_W-1:0]        dlm;
      logic                   dl_neg;
      logic                   corr_en;
      logic                   psi_cap;
      logic [FL_W-1:0]        psi;
      logic [PLO_W-1:0]       p_lo;
      logic [PHI_W-1:0]       p_hi;
      logic [FL_W-1:0]        c;
      logic [FL_W-1:0]        flux1;
      logic [FR_W-1:0]        omm;
      logic                   om_neg;
      logic [FL_W-1:0]        m;
      logic [FR_W-1:0]        m2;
      logic [FL_W-1:0]        corr;
   } face_type;

   localparam int PAY_W = $bits(face_type);

   logic [SCALE_W-1:0] courant_scale;
   logic               advance;

   // ---------------------------------------------------------------- config
   tsff_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .courant_scale (courant_scale)
   );

   // Hold every stage while the result register is full and not taken
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------- stage 1
   logic              s1_valid_ff;
   face_type          s1_ff, s1_in;
   logic [FR_W-1:0]   s1_dum_ff, s1_dum_in;
   logic [VW-1:0]     vraw, vmag;
   logic [VMAG_W-1:0] vmag_x;
   logic [FR_W-1:0]   uu, donor, acc;
   logic              du_neg;
   logic signed [FL_W-1:0] one_minus_acc, donor_s;

   // Take the face apart: velocity magnitude, differences, upper bound
   always_comb begin
      vraw   = req_tdata[VW-1:0];
      vmag   = vraw[VW-1] ? (~vraw + VW'(1)) : vraw;
      vmag_x = VMAG_W'(vmag);
      uu     = req_tdata[UU_LSB +: FR_W];
      donor  = req_tdata[DON_LSB +: FR_W];
      acc    = req_tdata[ACC_LSB +: FR_W];

      s1_in          = '0;
      s1_in.vsat     = (vmag_x > VMAG_W'(COURANT_CAP)) ? COURANT_CAP : vmag_x[VSAT_W-1:0];
      s1_in.neg_out  = vraw[VW-1] | (vraw == '0);
      s1_in.donor    = donor;
      s1_in.dl_neg   = acc < donor;
      s1_in.dlm      = s1_in.dl_neg ? (donor - acc) : (acc - donor);
      du_neg         = uu > donor;
      s1_dum_in      = du_neg ? (uu - donor) : (donor - uu);
      s1_in.corr_en  = req_tuser[0] && (acc != donor) && (s1_dum_in != '0)
                       && (du_neg == s1_in.dl_neg);
      s1_in.psi_cap  = {1'b0, s1_dum_in} >= {s1_in.dlm, 1'b0};
      one_minus_acc  = $signed(ONE_FL) - $signed({1'b0, acc});
      donor_s        = $signed({1'b0, donor});
      s1_in.ub       = (donor_s < one_minus_acc) ? donor_s : one_minus_acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff     <= s1_in;
         s1_dum_ff <= s1_dum_in;
      end
   end

   // ---------------------------------------------------------------- ratio
   logic            d_valid;
   logic [FR_W-1:0] d_quo;
   logic [PAY_W-1:0] d_pay;

   tsff_ratio_div #(
      .DEN_W (FR_W),
      .QUO_W (FR_W),
      .PAY_W (PAY_W)
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_dum_ff),
      .in_den    (s1_ff.dlm),
      .in_pay    (s1_ff),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_pay   (d_pay)
   );

   // ---------------------------------------------------------------- stages A..F
   logic     a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;
   face_type a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in, f_ff, f_in;
   logic [FL_W-1:0]   r_x;
   logic [PROD_W-1:0] prod;
   logic [FL_W-1:0]   om_diff;
   logic [MUL_W-1:0]  p_cd, p_co, p_md, p_pm;

   // A: superbee psi from the ratio, partial products of the Courant number
   always_comb begin
      a_in = face_type'(d_pay);
      r_x  = FL_W'(d_quo);
      if (a_in.psi_cap) begin
         a_in.psi = TWO_FL;
      end else if (r_x < HALF_FL) begin
         a_in.psi = r_x << 1;
      end else if (r_x < ONE_FL) begin
         a_in.psi = ONE_FL;
      end else begin
         a_in.psi = r_x;
      end
      a_in.p_lo = a_in.vsat[MUL_SPLIT-1:0] * courant_scale;
      a_in.p_hi = a_in.vsat[VSAT_W-1:MUL_SPLIT] * courant_scale;
   end

   // B: sum the partial products, saturate at 2.0, rescale
   always_comb begin
      b_in = a_ff;
      prod = PROD_W'(a_ff.p_lo) + (PROD_W'(a_ff.p_hi) << MUL_SPLIT);
      b_in.c = (prod >= PROD_W'(COURANT_CAP)) ? TWO_FL
                                              : prod[SCALE_FRAC_BITS-F +: FL_W];
   end

   // C: first-order flux and |1 - C|
   always_comb begin
      c_in        = b_ff;
      p_cd        = {{FR_W{1'b0}}, b_ff.c} * {{FL_W{1'b0}}, b_ff.donor};
      c_in.flux1  = p_cd[F +: FL_W];
      c_in.om_neg = b_ff.c > ONE_FL;
      om_diff     = c_in.om_neg ? (b_ff.c - ONE_FL) : (ONE_FL - b_ff.c);
      c_in.omm    = om_diff[FR_W-1:0];
   end

   // D: C * |1 - C|
   always_comb begin
      d_in   = c_ff;
      p_co   = {{FR_W{1'b0}}, c_ff.c} * {{FL_W{1'b0}}, c_ff.omm};
      d_in.m = p_co[F +: FL_W];
   end

   // E: times the local difference, halved
   always_comb begin
      e_in    = d_ff;
      p_md    = {{FR_W{1'b0}}, d_ff.m} * {{FL_W{1'b0}}, d_ff.dlm};
      e_in.m2 = p_md[F+1 +: FR_W];
   end

   // F: limited correction, dropped when the limiter does not apply
   always_comb begin
      f_in      = e_ff;
      p_pm      = {{FR_W{1'b0}}, e_ff.psi} * {{FL_W{1'b0}}, e_ff.m2};
      f_in.corr = e_ff.corr_en ? p_pm[F +: FL_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= d_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
         f_ff <= f_in;
      end
   end

   // ---------------------------------------------------------------- result
   logic                    rsp_tvalid_ff;
   logic [FL_W-1:0]         flux_ff, flux_in;
   logic signed [SUM_W-1:0] sum, ub_x, clamped;
   logic [FL_W-1:0]         mag;

   // Apply the correction, clamp to [0, bound], give it the velocity's sign
   always_comb begin
      if (f_ff.om_neg ^ f_ff.dl_neg) begin
         sum = $signed({2'b00, f_ff.flux1}) - $signed({2'b00, f_ff.corr});
      end else begin
         sum = $signed({2'b00, f_ff.flux1}) + $signed({2'b00, f_ff.corr});
      end
      ub_x    = $signed({{2{f_ff.ub[FL_W-1]}}, f_ff.ub});
      clamped = (sum > ub_x) ? ub_x : sum;
      mag     = (clamped < 0) ? '0 : clamped[FL_W-1:0];
      flux_in = f_ff.neg_out ? (~mag + FL_W'(1)) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flux_ff <= flux_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(flux_ff);

endmodule

/* rtl/tsff_checker.sv */
// Port-level checks on the face flux core, attached to it by bind.
// Depends only on the ports of tvd_superbee_face_flux_core.

module tsff_checker #(
   parameter int FRACTION_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((FRACTION_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int FL_W = FRACTION_BITS + 2;
   localparam logic signed [FL_W-1:0] ONE_FL = FL_W'(1) << FRACTION_BITS;
   localparam logic signed [FL_W-1:0] NEG_ONE_FL = -ONE_FL;

   logic signed [FL_W-1:0] flux;
   assign flux = $signed(rsp_tdata[FL_W-1:0]);

   // A stalled result transaction holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input is taken exactly when the result register can move on
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track the result stall");

   // Nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A flux never moves more than one cell's worth
   a_flux_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (flux <= ONE_FL) && (flux >= NEG_ONE_FL))
      else $error("flux outside [-1, 1]");

endmodule

bind tvd_superbee_face_flux_core tsff_checker #(
   .FRACTION_BITS (FRACTION_BITS)
) u_tsff_checker (.*);
